@@ hdl/plasma_pixel_threshold_defines.svh @@
// Assertion macros shared by the plasma pixel threshold checker
`ifndef PLASMA_PIXEL_THRESHOLD_DEFINES_SVH
`define PLASMA_PIXEL_THRESHOLD_DEFINES_SVH

// Implication checked at every rising clock edge outside reset
`define PPT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be seen outside reset
`define PPT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ hdl/ppt_pkg.sv @@
// Package: widths, constants, sine table and phase helpers for the plasma pixel threshold
package ppt_pkg;

  localparam int X_W   = 5;
  localparam int Y_W   = 4;
  localparam int T_W   = 16;
  localparam int THR_W = 15;

  localparam int AREA_WIDTH_DEF  = 20;
  localparam int AREA_HEIGHT_DEF = 16;

  localparam int PH_W  = 16;
  localparam int ANG_W = 21;
  localparam int TQ_W  = 20;
  localparam int SIN_W = 14;
  localparam int S12_W = 15;
  localparam int SUM_W = 16;
  localparam int D_W   = 18;

  localparam int SQ_IN_W    = 36;
  localparam int SQ_OUT_W   = 18;
  localparam int SQ_PER_STG = 2;
  localparam int SQ_STAGES  = SQ_OUT_W / SQ_PER_STG;

  localparam int PPT_LATENCY = 10 + SQ_STAGES;

  localparam logic signed [THR_W-1:0] THR_RESET = 15'sd819;

  localparam logic [17:0] PH_K      = 18'd166886;
  localparam logic [19:0] DIV3_K    = 20'd699051;
  localparam logic [11:0] KX        = 12'd2458;
  localparam logic [10:0] KY        = 11'd1638;
  localparam logic [10:0] KD        = 11'd1229;
  localparam logic [PH_W-1:0] QTURN = 16'd16384;

  localparam logic [12:0] QWAVE [0:32] = '{
    13'd0,    13'd201,  13'd401,  13'd601,  13'd799,  13'd995,  13'd1189, 13'd1380,
    13'd1567, 13'd1751, 13'd1931, 13'd2106, 13'd2276, 13'd2440, 13'd2598, 13'd2751,
    13'd2896, 13'd3035, 13'd3166, 13'd3290, 13'd3406, 13'd3513, 13'd3612, 13'd3703,
    13'd3784, 13'd3857, 13'd3920, 13'd3973, 13'd4017, 13'd4052, 13'd4076, 13'd4091,
    13'd4096
  };

  typedef struct packed {
    logic [X_W-1:0]          x;
    logic [Y_W-1:0]          y;
    logic [TQ_W-1:0]         tq;
    logic signed [S12_W-1:0] s12;
  } ppt_tag_t;

  function automatic logic [PH_W-1:0] to_phase(input logic [ANG_W-1:0] ang);
    logic [38:0] prod;
    prod = 39'(ang) * 39'(PH_K);
    return prod[31:16];
  endfunction

  function automatic logic signed [SIN_W-1:0] sin_phase(input logic [PH_W-1:0] ph);
    logic [14:0] m;
    logic [5:0]  idx;
    logic [8:0]  frac;
    logic [12:0] lo;
    logic [12:0] hi;
    logic [17:0] prod;
    logic [12:0] mag;
    m    = ph[14] ? (15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    idx  = m[14:9];
    frac = m[8:0];
    lo   = 13'd0;
    hi   = 13'd0;
    prod = 18'd0;
    if (idx >= 6'd32) begin
      mag = 13'd4096;
    end else begin
      lo   = QWAVE[idx];
      hi   = QWAVE[idx + 6'd1];
      prod = 18'(hi - lo) * 18'(frac) + 18'd256;
      mag  = lo + 13'(prod[17:9]);
    end
    return ph[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

@@ hdl/ppt_sqrt.sv @@
// Pipelined integer square root, two result bits per stage, with a tag carried alongside
module ppt_sqrt #(
  parameter int TAG_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [ppt_pkg::SQ_IN_W-1:0]   in_rad,
  input  logic [TAG_W-1:0]              in_tag,
  output logic                          out_vld,
  output logic [ppt_pkg::SQ_OUT_W-1:0]  out_root,
  output logic [TAG_W-1:0]              out_tag
);
  import ppt_pkg::*;

  localparam int REM_W = SQ_OUT_W + 3;

  logic                vld_r  [SQ_STAGES];
  logic [SQ_IN_W-1:0]  rad_r  [SQ_STAGES];
  logic [REM_W-1:0]    rem_r  [SQ_STAGES];
  logic [SQ_OUT_W-1:0] root_r [SQ_STAGES];
  logic [TAG_W-1:0]    tag_r  [SQ_STAGES];

  genvar g;
  for (g = 0; g < SQ_STAGES; g++) begin : g_stg
    logic                vld_src;
    logic [SQ_IN_W-1:0]  rad_src;
    logic [REM_W-1:0]    rem_src;
    logic [SQ_OUT_W-1:0] root_src;
    logic [TAG_W-1:0]    tag_src;
    logic [SQ_IN_W-1:0]  rad_nxt;
    logic [REM_W-1:0]    rem_nxt;
    logic [SQ_OUT_W-1:0] root_nxt;

    if (g == 0) begin : g_head
      assign vld_src  = in_vld;
      assign rad_src  = in_rad;
      assign rem_src  = '0;
      assign root_src = '0;
      assign tag_src  = in_tag;
    end else begin : g_body
      assign vld_src  = vld_r[g-1];
      assign rad_src  = rad_r[g-1];
      assign rem_src  = rem_r[g-1];
      assign root_src = root_r[g-1];
      assign tag_src  = tag_r[g-1];
    end

    always_comb begin
      rad_nxt  = rad_src;
      rem_nxt  = rem_src;
      root_nxt = root_src;
      for (int k = 0; k < SQ_PER_STG; k++) begin
        rem_nxt = {rem_nxt[REM_W-3:0], rad_nxt[SQ_IN_W-1 -: 2]};
        rad_nxt = {rad_nxt[SQ_IN_W-3:0], 2'b00};
        if (rem_nxt >= REM_W'({root_nxt, 2'b01})) begin
          rem_nxt  = rem_nxt - REM_W'({root_nxt, 2'b01});
          root_nxt = {root_nxt[SQ_OUT_W-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[SQ_OUT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_src;
      end
      rad_r[g]  <= rad_nxt;
      rem_r[g]  <= rem_nxt;
      root_r[g] <= root_nxt;
      tag_r[g]  <= tag_src;
    end
  end

  assign out_vld  = vld_r[SQ_STAGES-1];
  assign out_root = root_r[SQ_STAGES-1];
  assign out_tag  = tag_r[SQ_STAGES-1];

endmodule

@@ hdl/plasma_pixel_threshold.sv @@
// Top level: plasma field pixel generator with threshold, one pixel per clock
//
//  channel  | ports                                          | transfer
//  ---------+------------------------------------------------+------------------------
//  input    | start, busy, in_pixel_x/y, in_time_phase       | start && !busy
//  result   | out_valid, out_x, out_y, out_pixel_on          | out_valid, one cycle
//  config   | cfg_we, cfg_wdata                              | cfg_we
//
//  One pixel enters per clock; its result strobes on out_valid after passing the pipeline,
//  which is the nine-stage square root plus ten stages of phase, sine and sum.
//  busy is high only during reset; rst_n clears every stage valid and sets the threshold to 819.
//  The receiver cannot stall; nothing in the pipeline waits on it.
module plasma_pixel_threshold #(
  parameter int AREA_WIDTH  = ppt_pkg::AREA_WIDTH_DEF,
  parameter int AREA_HEIGHT = ppt_pkg::AREA_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ppt_pkg::X_W-1:0]           in_pixel_x,
  input  logic [ppt_pkg::Y_W-1:0]           in_pixel_y,
  input  logic [ppt_pkg::T_W-1:0]           in_time_phase,
  input  logic                              cfg_we,
  input  logic signed [ppt_pkg::THR_W-1:0]  cfg_wdata,
  output logic                              out_valid,
  output logic [ppt_pkg::X_W-1:0]           out_x,
  output logic [ppt_pkg::Y_W-1:0]           out_y,
  output logic                              out_pixel_on
);
  import ppt_pkg::*;

  logic signed [THR_W-1:0] thr_r;

  logic                    v0_r;
  logic [X_W-1:0]          x0_r;
  logic [Y_W-1:0]          y0_r;
  logic [TQ_W-1:0]         tq0_r;
  logic [ANG_W-1:0]        ang1_r;
  logic [ANG_W-1:0]        ang2_r;
  logic [ANG_W-1:0]        ang3_r;

  logic                    v1_r;
  logic [X_W-1:0]          x1_r;
  logic [Y_W-1:0]          y1_r;
  logic [TQ_W-1:0]         tq1_r;
  logic [PH_W-1:0]         ph1_r;
  logic [PH_W-1:0]         ph2_r;
  logic [PH_W-1:0]         phc_r;
  logic [TQ_W-1:0]         tq3_r;
  logic [40:0]             div_prod;

  logic                    v2_r;
  logic [X_W-1:0]          x2_r;
  logic [Y_W-1:0]          y2_r;
  logic [TQ_W-1:0]         tq2_r;
  logic [PH_W-1:0]         phs_r;
  logic signed [S12_W-1:0] s12_2_r;
  logic signed [SIN_W-1:0] cc2_r;

  logic                    v3_r;
  ppt_tag_t                tag3_r;
  logic signed [SIN_W-1:0] sc3_r;
  logic signed [SIN_W-1:0] cc3_r;

  logic                    v4_r;
  ppt_tag_t                tag4_r;
  logic signed [D_W-1:0]   dx_r;
  logic signed [D_W-1:0]   dy_r;
  logic signed [D_W-1:0]   sc_ext;
  logic signed [D_W-1:0]   cc_ext;
  logic signed [D_W-1:0]   cx;
  logic signed [D_W-1:0]   cy;

  logic                    v5_r;
  ppt_tag_t                tag5_r;
  logic [SQ_IN_W-1:0]      rad_r;
  logic signed [SQ_IN_W-1:0] sqx;
  logic signed [SQ_IN_W-1:0] sqy;

  logic                    sq_vld;
  logic [SQ_OUT_W-1:0]     sq_root;
  logic [$bits(ppt_tag_t)-1:0] sq_tag;

  logic                    v6_r;
  ppt_tag_t                tag6_r;
  logic [28:0]             dp_r;

  logic                    v7_r;
  ppt_tag_t                tag7_r;
  logic [PH_W-1:0]         ph3_r;

  logic                    v8_r;
  ppt_tag_t                tag8_r;
  logic signed [SIN_W-1:0] s3_r;

  logic signed [SUM_W-1:0] vsum;
  logic                    in_area;

  logic                    out_valid_r;
  logic [X_W-1:0]          out_x_r;
  logic [Y_W-1:0]          out_y_r;
  logic                    out_on_r;

  assign busy = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
    x0_r   <= in_pixel_x;
    y0_r   <= in_pixel_y;
    tq0_r  <= {in_time_phase, 4'd0};
    ang1_r <= ANG_W'(in_pixel_x) * ANG_W'(KX) + ANG_W'({in_time_phase, 4'd0});
    ang2_r <= ANG_W'(in_pixel_y) * ANG_W'(KY) + ANG_W'({in_time_phase, 3'd0});
    ang3_r <= ANG_W'({in_time_phase, 3'd0});
  end

  assign div_prod = 41'(tq0_r) * 41'(DIV3_K);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    x1_r  <= x0_r;
    y1_r  <= y0_r;
    tq1_r <= tq0_r;
    ph1_r <= to_phase(ang1_r);
    ph2_r <= to_phase(ang2_r) + QTURN;
    phc_r <= to_phase(ang3_r) + QTURN;
    tq3_r <= div_prod[40:21];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    x2_r    <= x1_r;
    y2_r    <= y1_r;
    tq2_r   <= tq1_r;
    phs_r   <= to_phase(ANG_W'(tq3_r));
    s12_2_r <= S12_W'(sin_phase(ph1_r)) + S12_W'(sin_phase(ph2_r));
    cc2_r   <= sin_phase(phc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    tag3_r.x   <= x2_r;
    tag3_r.y   <= y2_r;
    tag3_r.tq  <= tq2_r;
    tag3_r.s12 <= s12_2_r;
    sc3_r      <= sin_phase(phs_r);
    cc3_r      <= cc2_r;
  end

  always_comb begin
    sc_ext = D_W'(sc3_r);
    cc_ext = D_W'(cc3_r);
    cx     = 18'sd40960 + (sc_ext <<< 3) + (sc_ext <<< 1);
    cy     = 18'sd32768 + (cc_ext <<< 3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    tag4_r <= tag3_r;
    dx_r   <= $signed({1'b0, tag3_r.x, 12'd0}) - cx;
    dy_r   <= $signed({1'b0, 1'b0, tag3_r.y, 12'd0}) - cy;
  end

  always_comb begin
    sqx = dx_r * dx_r;
    sqy = dy_r * dy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    tag5_r <= tag4_r;
    rad_r  <= SQ_IN_W'(sqx) + SQ_IN_W'(sqy);
  end

  ppt_sqrt #(
    .TAG_W($bits(ppt_tag_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v5_r),
    .in_rad   (rad_r),
    .in_tag   (tag5_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_tag  (sq_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= sq_vld;
    end
    tag6_r <= ppt_tag_t'(sq_tag);
    dp_r   <= 29'(sq_root) * 29'(KD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
    tag7_r <= tag6_r;
    ph3_r  <= to_phase(ANG_W'(dp_r[28:12]) + ANG_W'(tag6_r.tq));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
    tag8_r <= tag7_r;
    s3_r   <= sin_phase(ph3_r);
  end

  always_comb begin
    vsum    = SUM_W'(tag8_r.s12) + SUM_W'(s3_r);
    in_area = ({2'b00, tag8_r.x} < 7'(AREA_WIDTH)) && ({3'b000, tag8_r.y} < 7'(AREA_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_on_r    <= 1'b0;
    end else begin
      out_valid_r <= v8_r;
      out_on_r    <= v8_r && in_area && (vsum > SUM_W'(thr_r));
    end
    out_x_r <= tag8_r.x;
    out_y_r <= tag8_r.y;
  end

  assign out_valid    = out_valid_r;
  assign out_x        = out_x_r;
  assign out_y        = out_y_r;
  assign out_pixel_on = out_on_r;

endmodule

@@ hdl/ppt_checker.sv @@
// Port-level checker for the plasma pixel threshold, bound to the top level
`include "plasma_pixel_threshold_defines.svh"

module ppt_checker #(
  parameter int AREA_WIDTH  = ppt_pkg::AREA_WIDTH_DEF,
  parameter int AREA_HEIGHT = ppt_pkg::AREA_HEIGHT_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [ppt_pkg::X_W-1:0]           in_pixel_x,
  input logic [ppt_pkg::Y_W-1:0]           in_pixel_y,
  input logic                              out_valid,
  input logic [ppt_pkg::X_W-1:0]           out_x,
  input logic [ppt_pkg::Y_W-1:0]           out_y,
  input logic                              out_pixel_on
);
  import ppt_pkg::*;

  `PPT_ASSERT_IMPL(a_result_follows, start && !busy, ##PPT_LATENCY out_valid, "transfer produced no result")
  `PPT_ASSERT_IMPL(a_result_has_src, out_valid, $past(start && !busy, PPT_LATENCY), "result without transfer")
  `PPT_ASSERT_IMPL(a_coord_echo, out_valid, (out_x == $past(in_pixel_x, PPT_LATENCY)) && (out_y == $past(in_pixel_y, PPT_LATENCY)), "coordinate not echoed")
  `PPT_ASSERT_NEVER(a_outside_dark, out_pixel_on && (!out_valid || ({2'b00, out_x} >= 7'(AREA_WIDTH)) || ({3'b000, out_y} >= 7'(AREA_HEIGHT))), "pixel lit outside area or strobe")

endmodule

bind plasma_pixel_threshold ppt_checker #(
  .AREA_WIDTH  (AREA_WIDTH),
  .AREA_HEIGHT (AREA_HEIGHT)
) u_ppt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_pixel_x   (in_pixel_x),
  .in_pixel_y   (in_pixel_y),
  .out_valid    (out_valid),
  .out_x        (out_x),
  .out_y        (out_y),
  .out_pixel_on (out_pixel_on)
);

@@ tb/tb_top.sv @@
// Testbench for the plasma pixel threshold: directed table, threshold writes, then random pixels
`timescale 1ns / 1ps

module tb_top;
  import ppt_pkg::*;

  localparam int LAT       = PPT_LATENCY;
  localparam int CYC_LIMIT = 200000;

  typedef struct {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           on;
  } pix_res_t;

  typedef struct {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [T_W-1:0] t;
    bit             has_on;
    logic           on;
  } stim_row_t;

  localparam int QW [0:32] = '{
    0, 201, 401, 601, 799, 995, 1189, 1380, 1567, 1751, 1931,
    2106, 2276, 2440, 2598, 2751, 2896, 3035, 3166, 3290, 3406,
    3513, 3612, 3703, 3784, 3857, 3920, 3973, 4017, 4052, 4076,
    4091, 4096
  };

  logic clk, rst_n, start, busy, cfg_we;
  logic [X_W-1:0] in_pixel_x, out_x;
  logic [Y_W-1:0] in_pixel_y, out_y;
  logic [T_W-1:0] in_time_phase;
  logic signed [THR_W-1:0] cfg_wdata;
  logic out_valid, out_pixel_on;

  pix_res_t pending_pixels[$];
  int  errors;
  int  cycles;
  int  idle_pct;
  longint thr_now;

  plasma_pixel_threshold i_dut (
    .clk, .rst_n, .start, .busy, .in_pixel_x, .in_pixel_y, .in_time_phase,
    .cfg_we, .cfg_wdata, .out_valid, .out_x, .out_y, .out_pixel_on
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic longint wave_sin(longint ph);
    longint quad, w, m, i, f, v;
    ph   = ph & 64'hFFFF;
    quad = ph >> 14;
    w    = ph & 64'h3FFF;
    m    = quad[0] ? 16384 - w : w;
    i    = m >> 9;
    f    = m & 511;
    if (i >= 32) v = 4096;
    else v = QW[i] + (((QW[i+1] - QW[i]) * f + 256) >> 9);
    return quad[1] ? -v : v;
  endfunction

  function automatic longint rad_to_phase(longint a);
    return ((a * 166886) >> 16) & 64'hFFFF;
  endfunction

  function automatic longint int_root(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic pixel_lit(longint x, longint y, longint t, longint thr);
    longint tq, s1, s2, s3, sc, cc, dx, dy, d, v;
    tq = t * 16;
    s1 = wave_sin(rad_to_phase(x * 2458 + tq));
    s2 = wave_sin(rad_to_phase(y * 1638 + t * 8) + 16384);
    sc = wave_sin(rad_to_phase(tq / 3));
    cc = wave_sin(rad_to_phase(t * 8) + 16384);
    dx = x * 4096 - (40960 + 10 * sc);
    dy = y * 4096 - (32768 + 8 * cc);
    d  = int_root(dx * dx + dy * dy);
    s3 = wave_sin(rad_to_phase(((d * 1229) >> 12) + tq));
    v  = s1 + s2 + s3;
    return (v > thr) && (x < AREA_WIDTH_DEF) && (y < AREA_HEIGHT_DEF);
  endfunction

  always @(posedge clk) begin
    pix_res_t exp_pix;
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result x=%0d y=%0d", out_x, out_y);
        errors++;
      end else begin
        exp_pix = pending_pixels.pop_front();
        if (out_x !== exp_pix.x) begin
          $error("out_x expected %0d actual %0d", exp_pix.x, out_x); errors++;
        end
        if (out_y !== exp_pix.y) begin
          $error("out_y expected %0d actual %0d", exp_pix.y, out_y); errors++;
        end
        if (out_pixel_on !== exp_pix.on) begin
          $error("pixel_on expected %0d actual %0d", exp_pix.on, out_pixel_on); errors++;
        end
      end
    end
  end

  task automatic send_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y, logic [T_W-1:0] t,
                            bit has_on, logic on_val);
    pix_res_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    in_pixel_x    <= x;
    in_pixel_y    <= y;
    in_time_phase <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    r.x  = x;
    r.y  = y;
    r.on = has_on ? on_val : pixel_lit(x, y, t, thr_now);
    pending_pixels.push_back(r);
    @(negedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    while (n < LAT + 4) begin
      @(negedge clk);
      n++;
    end
  endtask

  task automatic write_threshold(logic signed [THR_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    thr_now = longint'(v);
  endtask

  task automatic random_pixels(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_pixel(X_W'($urandom), Y_W'($urandom), T_W'($urandom), 0, 1'b0);
      else
        send_pixel(X_W'($urandom_range(19)), Y_W'($urandom_range(15)),
                   T_W'($urandom), 0, 1'b0);
    end
  endtask

  stim_row_t dir_rows[] = '{
    '{5'd0,  4'd0,  16'd0,     0, 1'b0},
    '{5'd19, 4'd15, 16'd0,     0, 1'b0},
    '{5'd19, 4'd15, 16'hFFFF,  0, 1'b0},
    '{5'd0,  4'd0,  16'hFFFF,  0, 1'b0},
    '{5'd10, 4'd8,  16'd12345, 0, 1'b0},
    '{5'd20, 4'd0,  16'd100,   1, 1'b0},
    '{5'd31, 4'd7,  16'd4000,  1, 1'b0},
    '{5'd31, 4'd15, 16'hFFFF,  1, 1'b0},
    '{5'd5,  4'd3,  16'h8000,  0, 1'b0},
    '{5'd15, 4'd12, 16'h5555,  0, 1'b0},
    '{5'd1,  4'd1,  16'hAAAA,  0, 1'b0},
    '{5'd18, 4'd14, 16'd804,   0, 1'b0}
  };

  initial begin
    errors = 0; cycles = 0; idle_pct = 0;
    thr_now = 819;
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_pixel_x = '0; in_pixel_y = '0; in_time_phase = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      send_pixel(dir_rows[i].x, dir_rows[i].y, dir_rows[i].t,
                 dir_rows[i].has_on, dir_rows[i].on);
    drain();

    write_threshold(15'sd12288);
    send_pixel(5'd3, 4'd4, 16'd777, 1, 1'b0);
    send_pixel(5'd9, 4'd9, 16'd30000, 1, 1'b0);
    drain();
    write_threshold(-15'sd16384);
    send_pixel(5'd3, 4'd4, 16'd777, 1, 1'b1);
    send_pixel(5'd25, 4'd4, 16'd777, 1, 1'b0);
    drain();
    write_threshold(15'sd16383);
    send_pixel(5'd0, 4'd0, 16'd0, 1, 1'b0);
    drain();

    write_threshold(15'sd819);
    random_pixels(200);
    drain();
    idle_pct = 71;
    write_threshold(-15'sd12288);
    random_pixels(150);
    drain();
    idle_pct = 38;
    write_threshold(15'sd0);
    random_pixels(200);
    drain();
    idle_pct = 0;
    write_threshold(-15'sd2000);
    random_pixels(250);
    drain();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/ppt_pkg.sv
hdl/ppt_sqrt.sv
hdl/plasma_pixel_threshold.sv
hdl/ppt_checker.sv
tb/tb_top.sv
